// ===== rtl/mhs_pkg.sv =====
// Shared constants, types and codes of the MinHash signature engine.
package mhs_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int SLOT_W = 6;
    localparam int HASH_W = 32;
    localparam int DATA_W = 64;
    localparam logic [HASH_W-1:0] PRIME = 32'hFFFF_FFFB;
    localparam logic [HASH_W-1:0] MIN_INIT = {HASH_W{1'b1}};
    localparam int CELL_LAT = 5;
    localparam int DRAIN_CYCLES = SLOT_COUNT + CELL_LAT;
    localparam int DRAIN_W = $clog2(DRAIN_CYCLES + 1);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SHINGLE = 1'b1;

    typedef logic [SLOT_W-1:0] t_slot;

    typedef struct packed {
        logic              vld;
        logic              load;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] data;
    } t_tok;

endpackage

// ===== rtl/mhs_cell.sv =====
// One hash slot of the chain: coefficient pair, hash pipeline and running minimum.
module mhs_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mhs_pkg::t_slot              i_index,
    input  mhs_pkg::t_tok               i_tok,
    output mhs_pkg::t_tok               o_tok,
    input  logic                        i_shift,
    input  logic [mhs_pkg::HASH_W-1:0]  i_min_next,
    output logic [mhs_pkg::HASH_W-1:0]  o_min
);

    mhs_pkg::t_tok               r_tok;
    logic [mhs_pkg::HASH_W-1:0]  r_a;
    logic [mhs_pkg::HASH_W-1:0]  r_b;
    logic                        r_s1_v;
    logic [63:0]                 r_s1_lo;
    logic [31:0]                 r_s1_hi;
    logic [mhs_pkg::HASH_W-1:0]  r_s1_b;
    logic                        r_s2_v;
    logic [63:0]                 r_s2_t;
    logic                        r_s3_v;
    logic [34:0]                 r_s3;
    logic                        r_s4_v;
    logic [32:0]                 r_s4;
    logic [mhs_pkg::HASH_W-1:0]  r_min;

    logic                        w_shingle;
    logic [63:0]                 w_prod_lo;
    logic [31:0]                 w_prod_hi;
    logic [63:0]                 w_sum;
    logic [34:0]                 w_fold1;
    logic [32:0]                 w_fold2;
    logic [32:0]                 w_red;
    logic [mhs_pkg::HASH_W-1:0]  w_val;

    assign w_shingle = r_tok.vld && !r_tok.load;

    // The product is taken modulo 2^64, so only the low half of a * x_hi is kept.
    assign w_prod_lo = r_a * r_tok.data[31:0];
    assign w_prod_hi = r_a * r_tok.data[63:32];
    assign w_sum = r_s1_lo + {r_s1_hi, 32'h0} + {32'h0, r_s1_b};

    // Since 2^32 is 5 modulo the prime, each fold replaces hi * 2^32 by hi * 5.
    assign w_fold1 = {1'b0, r_s2_t[63:32], 2'b00} + {3'b000, r_s2_t[63:32]}
                   + {3'b000, r_s2_t[31:0]};
    assign w_fold2 = {28'h0, r_s3[34:32], 2'b00} + {30'h0, r_s3[34:32]}
                   + {1'b0, r_s3[31:0]};
    assign w_red = (r_s4 >= {1'b0, mhs_pkg::PRIME}) ? r_s4 - {1'b0, mhs_pkg::PRIME} : r_s4;
    assign w_val = w_red[31:0];

    always_ff @(posedge i_clk) begin
        r_tok.load <= i_tok.load;
        r_tok.slot <= i_tok.slot;
        r_tok.data <= i_tok.data;
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_s3_v    <= 1'b0;
            r_s4_v    <= 1'b0;
            r_min     <= mhs_pkg::MIN_INIT;
        end else begin
            r_tok.vld <= i_tok.vld;
            r_s1_v    <= w_shingle;
            r_s2_v    <= r_s1_v;
            r_s3_v    <= r_s2_v;
            r_s4_v    <= r_s3_v;
            if (i_shift) begin
                r_min <= i_min_next;
            end else if (r_s4_v && (w_val < r_min)) begin
                r_min <= w_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_tok.vld && r_tok.load && (r_tok.slot == i_index)) begin
            r_a <= r_tok.data[63:32];
            r_b <= r_tok.data[31:0];
        end
        r_s1_lo <= w_prod_lo;
        r_s1_hi <= w_prod_hi;
        r_s1_b  <= r_b;
        r_s2_t  <= w_sum;
        r_s3    <= w_fold1;
        r_s4    <= w_fold2;
    end

    assign o_tok = r_tok;
    assign o_min = r_min;

    a_s1_from_shingle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v |-> $past(r_tok.vld && !r_tok.load))
        else $error("hash pipeline started without a shingle");

    a_fold_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_v |-> (r_s4 < ({1'b0, mhs_pkg::PRIME} << 1)))
        else $error("folded value not below twice the prime");

    a_shift_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_shift |-> !r_s4_v)
        else $error("minimum shifted while an update was pending");

endmodule

// ===== rtl/minhash_signature_engine.sv =====
// Top level of the MinHash signature engine: input control, cell chain and result port.
//
// Input channel (i_valid / o_stall): a load transfer (cmd 0) writes the coefficient
// pair of one slot; a shingle transfer (cmd 1) updates the minima of all slots.
// Both kinds are taken one per cycle while o_stall is low. Items travel down a chain
// of SLOT_COUNT cells, one cell per cycle, and each cell folds a hash into its
// minimum through a pipeline of its own.
// A shingle marked doc_end makes o_stall rise on the next cycle. The block then
// waits for the chain to empty and shifts the minima out of the chain on the
// output channel (o_valid / i_stall), slot 0 first, one transfer per cycle while
// the receiver does not stall, sig_last set on the final slot. Shifting the minima
// out also sets them back to all ones. When the receiver stalls, the result
// register holds and the shift pauses; o_stall stays high until the last result
// has left the chain.
// Reset clears the minima to all ones and empties the chain; coefficients stay
// undefined until loaded.
module minhash_signature_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_cmd,
    input  logic [mhs_pkg::SLOT_W-1:0]  i_slot,
    input  logic [31:0]                 i_coef_mul,
    input  logic [31:0]                 i_coef_add,
    input  logic [63:0]                 i_shingle,
    input  logic                        i_doc_end,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [mhs_pkg::SLOT_W-1:0]  o_sig_slot,
    output logic [mhs_pkg::HASH_W-1:0]  o_sig_value,
    output logic                        o_sig_last
);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    t_state                       r_state;
    logic [mhs_pkg::DRAIN_W-1:0]  r_cnt;
    mhs_pkg::t_slot               r_idx;
    logic                         r_o_valid;
    mhs_pkg::t_slot               r_sig_slot;
    logic [mhs_pkg::HASH_W-1:0]   r_sig_value;
    logic                         r_sig_last;

    mhs_pkg::t_tok                w_tok [0:mhs_pkg::SLOT_COUNT];
    logic [mhs_pkg::HASH_W-1:0]   w_min [0:mhs_pkg::SLOT_COUNT];
    logic                         w_accept;
    logic                         w_shift;
    logic                         w_idx_last;

    assign o_stall = (r_state != ST_RUN);
    assign w_accept = i_valid && !o_stall;
    assign w_shift = (r_state == ST_EMIT) && (!r_o_valid || !i_stall);
    assign w_idx_last = (r_idx == mhs_pkg::t_slot'(mhs_pkg::SLOT_COUNT - 1));

    assign w_tok[0].vld = w_accept;
    assign w_tok[0].load = (i_cmd == mhs_pkg::CMD_LOAD);
    assign w_tok[0].slot = i_slot;
    assign w_tok[0].data = (i_cmd == mhs_pkg::CMD_LOAD) ? {i_coef_mul, i_coef_add} : i_shingle;
    assign w_min[mhs_pkg::SLOT_COUNT] = mhs_pkg::MIN_INIT;

    for (genvar k = 0; k < mhs_pkg::SLOT_COUNT; k++) begin : g_cell
        mhs_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_index    (mhs_pkg::t_slot'(k)),
            .i_tok      (w_tok[k]),
            .o_tok      (w_tok[k+1]),
            .i_shift    (w_shift),
            .i_min_next (w_min[k+1]),
            .o_min      (w_min[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_RUN;
            r_cnt     <= '0;
            r_idx     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_shift) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_RUN: begin
                    if (w_accept && (i_cmd == mhs_pkg::CMD_SHINGLE) && i_doc_end) begin
                        r_state <= ST_DRAIN;
                        r_cnt   <= mhs_pkg::DRAIN_W'(mhs_pkg::DRAIN_CYCLES);
                    end
                end
                ST_DRAIN: begin
                    if (r_cnt == '0) begin
                        r_state <= ST_EMIT;
                        r_idx   <= '0;
                    end else begin
                        r_cnt <= r_cnt - mhs_pkg::DRAIN_W'(1);
                    end
                end
                ST_EMIT: begin
                    if (w_shift) begin
                        r_idx <= r_idx + mhs_pkg::t_slot'(1);
                        if (w_idx_last) begin
                            r_state <= ST_RUN;
                        end
                    end
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_sig_slot  <= r_idx;
            r_sig_value <= w_min[0];
            r_sig_last  <= w_idx_last;
        end
    end

    assign o_valid = r_o_valid;
    assign o_sig_slot = r_sig_slot;
    assign o_sig_value = r_sig_value;
    assign o_sig_last = r_sig_last;

    a_doc_end_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd == mhs_pkg::CMD_SHINGLE) && i_doc_end) |=> o_stall)
        else $error("input not stalled after a document end transfer");

    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sig_last) |-> (o_sig_slot == mhs_pkg::t_slot'(mhs_pkg::SLOT_COUNT - 1)))
        else $error("last mark on a slot other than the final one");

    a_chain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_shift |-> !w_tok[mhs_pkg::SLOT_COUNT].vld)
        else $error("results shifted out while the chain still held items");

endmodule
